FILE: src/sqrot_pkg.sv
// ----------------------------------------------------------------------------
// sqrot_pkg
// shared constants and types of the square image rotation unit
// ----------------------------------------------------------------------------
`default_nettype none

package sqrot_pkg;

    localparam int MAX_SIDE_DEF   = 64;
    localparam int PIXEL_BITS_DEF = 32;
    localparam int SIZE_W         = 7;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [SIZE_W-1:0] MATRIX_SIZE_RESET = 7'd4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic is_write;
        logic not_ready;
        logic last;
    } ctl_t;

endpackage

`default_nettype wire

FILE: src/sqrot_ram.sv
// ----------------------------------------------------------------------------
// sqrot_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sqrot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/sqrot_front.sv
// ----------------------------------------------------------------------------
// sqrot_front
// accepts items, tracks load count and readout position, forms store addresses
// ----------------------------------------------------------------------------
`default_nettype none

module sqrot_front #(
    parameter int MAX_SIDE   = sqrot_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = sqrot_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [sqrot_pkg::SIZE_W-1:0]         matrix_size,
    input  wire logic                                 start,
    input  wire logic                                 queue_full,
    input  wire logic                                 operation,
    input  wire logic [PIXEL_BITS-1:0]                pixel_in,
    output logic                                      push,
    output sqrot_pkg::ctl_t                           push_ctl,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]      push_addr,
    output logic [PIXEL_BITS-1:0]                     push_data
);

    localparam int N_W     = $clog2(MAX_SIDE + 1);
    localparam int COORD_W = $clog2(MAX_SIDE);
    localparam int ADDR_W  = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CNT_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);

    logic [sqrot_pkg::SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]             load_count_reg, load_count_next;
    logic [COORD_W-1:0]           out_row_reg, out_row_next;
    logic [COORD_W-1:0]           out_col_reg, out_col_next;

    logic [N_W-1:0]     n;
    logic [CNT_W-1:0]   total;
    logic               complete;
    logic               pos_bad;
    logic [COORD_W-1:0] row_e;
    logic [COORD_W-1:0] col_e;
    logic [CNT_W-1:0]   src;
    logic               last;

    assign cfg_ready = 1'b1;
    assign push      = start && !queue_full;
    assign push_data = pixel_in;

    always_comb
    begin
        if (size_reg == '0)
        begin
            n = N_W'(1);
        end
        else if (32'(size_reg) > 32'(MAX_SIDE))
        begin
            n = N_W'(MAX_SIDE);
        end
        else
        begin
            n = N_W'(size_reg);
        end

        total    = CNT_W'(n) * CNT_W'(n);
        complete = load_count_reg >= total;
        pos_bad  = (N_W'(out_row_reg) >= n) || (N_W'(out_col_reg) >= n);
        row_e    = pos_bad ? '0 : out_row_reg;
        col_e    = pos_bad ? '0 : out_col_reg;
        src      = CNT_W'(n - N_W'(1) - N_W'(col_e)) * CNT_W'(n) + CNT_W'(row_e);
        last     = (N_W'(row_e) == n - N_W'(1)) && (N_W'(col_e) == n - N_W'(1));

        load_count_next = load_count_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        push_ctl        = '0;
        push_addr       = '0;

        if (operation == sqrot_pkg::OP_WRITE)
        begin
            push_ctl.is_write = 1'b1;
            if (complete)
            begin
                push_addr       = '0;
                load_count_next = CNT_W'(1);
                out_row_next    = '0;
                out_col_next    = '0;
            end
            else
            begin
                push_addr       = load_count_reg[ADDR_W-1:0];
                load_count_next = load_count_reg + CNT_W'(1);
            end
        end
        else if (!complete)
        begin
            push_ctl.not_ready = 1'b1;
        end
        else
        begin
            push_ctl.last = last;
            push_addr     = src[ADDR_W-1:0];
            if (N_W'(col_e) + N_W'(1) >= n)
            begin
                out_col_next = '0;
                if (N_W'(row_e) + N_W'(1) >= n)
                begin
                    out_row_next = '0;
                end
                else
                begin
                    out_row_next = row_e + COORD_W'(1);
                end
            end
            else
            begin
                out_col_next = col_e + COORD_W'(1);
                out_row_next = row_e;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= sqrot_pkg::MATRIX_SIZE_RESET;
            load_count_reg <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= matrix_size;
            end
            if (push)
            begin
                load_count_reg <= load_count_next;
                out_row_reg    <= out_row_next;
                out_col_reg    <= out_col_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/sqrot_queue.sv
// ----------------------------------------------------------------------------
// sqrot_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module sqrot_queue #(
    parameter int ADDR_W     = 12,
    parameter int PIXEL_BITS = sqrot_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire sqrot_pkg::ctl_t       push_ctl,
    input  wire logic [ADDR_W-1:0]     push_addr,
    input  wire logic [PIXEL_BITS-1:0] push_data,
    output logic                       full,
    output logic                       empty,
    input  wire logic                  pop,
    output sqrot_pkg::ctl_t            pop_ctl,
    output logic [ADDR_W-1:0]          pop_addr,
    output logic [PIXEL_BITS-1:0]      pop_data
);

    localparam int DEPTH = sqrot_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    sqrot_pkg::ctl_t        ctl_reg  [DEPTH];
    logic [ADDR_W-1:0]      addr_reg [DEPTH];
    logic [PIXEL_BITS-1:0]  data_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]         count_reg, count_next;
    logic                   do_push, do_pop;

    assign full     = count_reg == (PTR_W+1)'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_ctl  = ctl_reg[rd_ptr_reg];
    assign pop_addr = addr_reg[rd_ptr_reg];
    assign pop_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctl_reg[wr_ptr_reg]  <= push_ctl;
            addr_reg[wr_ptr_reg] <= push_addr;
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/sqrot_back.sv
// ----------------------------------------------------------------------------
// sqrot_back
// carries out store writes and reads, drives the result strobe
// ----------------------------------------------------------------------------
`default_nettype none

module sqrot_back #(
    parameter int ADDR_W     = 12,
    parameter int PIXEL_BITS = sqrot_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  empty,
    output logic                       pop,
    input  wire sqrot_pkg::ctl_t       pop_ctl,
    input  wire logic [ADDR_W-1:0]     pop_addr,
    input  wire logic [PIXEL_BITS-1:0] pop_data,
    output logic                       done,
    output logic [PIXEL_BITS-1:0]      pixel_out,
    output logic                       last_pixel,
    output logic                       not_ready
);

    logic                  we, re;
    logic [PIXEL_BITS-1:0] rdata;
    logic                  done_reg, done_next;
    logic                  last_reg, last_next;
    logic                  nr_reg, nr_next;

    assign pop       = !empty;
    assign we        = pop && pop_ctl.is_write;
    assign re        = pop && !pop_ctl.is_write && !pop_ctl.not_ready;
    assign done_next = pop && !pop_ctl.is_write;
    assign last_next = pop_ctl.last;
    assign nr_next   = pop_ctl.not_ready;

    sqrot_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (2 ** ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (pop_addr),
        .wdata (pop_data),
        .re    (re),
        .raddr (pop_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            last_reg <= 1'b0;
            nr_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (done_next)
            begin
                last_reg <= last_next;
                nr_reg   <= nr_next;
            end
        end
    end

    assign done       = done_reg;
    assign last_pixel = last_reg && !nr_reg;
    assign not_ready  = nr_reg;
    assign pixel_out  = nr_reg ? '0 : rdata;

endmodule

`default_nettype wire

FILE: src/square_image_rotate_ninety_unit.sv
// ----------------------------------------------------------------------------
// square_image_rotate_ninety_unit
// loads a square image in raster order and reads it back turned 90 degrees
// clockwise, also in raster order
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  item in   start, busy                operation, pixel_in
//  result    done (one-cycle strobe)    pixel_out, last_pixel, not_ready
//  config    cfg_valid, cfg_ready       matrix_size
//
//  one item per cycle sustained; a read result is on the result ports once its
//  item has passed the queue slot and then the registered store read
//  busy rises only when the two-entry queue is full; the back drains one
//  entry every cycle, so the queue never holds more than one and busy stays low
//  reset clears counters and position; the pixel store is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module square_image_rotate_ninety_unit #(
    parameter int MAX_SIDE   = sqrot_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = sqrot_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [sqrot_pkg::SIZE_W-1:0] matrix_size,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         operation,
    input  wire logic [PIXEL_BITS-1:0]        pixel_in,
    output logic                              done,
    output logic [PIXEL_BITS-1:0]             pixel_out,
    output logic                              last_pixel,
    output logic                              not_ready
);

    localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);

    logic                  push, full, empty, pop;
    sqrot_pkg::ctl_t       push_ctl, pop_ctl;
    logic [ADDR_W-1:0]     push_addr, pop_addr;
    logic [PIXEL_BITS-1:0] push_data, pop_data;

    assign busy = full;

    sqrot_front #(
        .MAX_SIDE   (MAX_SIDE),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .matrix_size (matrix_size),
        .start       (start),
        .queue_full  (full),
        .operation   (operation),
        .pixel_in    (pixel_in),
        .push        (push),
        .push_ctl    (push_ctl),
        .push_addr   (push_addr),
        .push_data   (push_data)
    );

    sqrot_queue #(
        .ADDR_W     (ADDR_W),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_addr (push_addr),
        .push_data (push_data),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .pop_ctl   (pop_ctl),
        .pop_addr  (pop_addr),
        .pop_data  (pop_data)
    );

    sqrot_back #(
        .ADDR_W     (ADDR_W),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop        (pop),
        .pop_ctl    (pop_ctl),
        .pop_addr   (pop_addr),
        .pop_data   (pop_data),
        .done       (done),
        .pixel_out  (pixel_out),
        .last_pixel (last_pixel),
        .not_ready  (not_ready)
    );

endmodule

`default_nettype wire

FILE: tb/sv/square_image_rotate_ninety_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// square_image_rotate_ninety_unit_tb
// self-checking bench for the square image rotation unit: loads images of
// many sizes, reads them back and checks each rotated pixel, its last flag
// and not-ready flag against a local model of the rotation, under random
// sender gaps and size changes between phases
// ----------------------------------------------------------------------------
`default_nettype none

module square_image_rotate_ninety_unit_tb;

    localparam int SIZE_W        = sqrot_pkg::SIZE_W;
    localparam int PIX_W         = sqrot_pkg::PIXEL_BITS_DEF;
    localparam int MAX_SIDE      = sqrot_pkg::MAX_SIDE_DEF;
    localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int LARGE_SIDE    = 20;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int ITEM_TARGET   = 1300;
    localparam int ITEM_SLACK    = 150;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             nrdy;
    } rot_pixel_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SIZE_W-1:0] matrix_size;
    logic              start;
    logic              busy;
    logic              operation;
    logic [PIX_W-1:0]  pixel_in;
    logic              done;
    logic [PIX_W-1:0]  pixel_out;
    logic              last_pixel;
    logic              not_ready;

    // local copy of the image state
    logic [PIX_W-1:0]  img_store [STORE_DEPTH];
    logic [SIZE_W-1:0] size_reg;
    int unsigned       loaded;
    int unsigned       rd_row;
    int unsigned       rd_col;

    rot_pixel_t        pending_pixels [$];
    int                fail_count;
    int                items_sent;
    bit                no_gaps;

    square_image_rotate_ninety_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .matrix_size(matrix_size),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .pixel_in   (pixel_in),
        .done       (done),
        .pixel_out  (pixel_out),
        .last_pixel (last_pixel),
        .not_ready  (not_ready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_pixels.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic int unsigned side_of(input logic [SIZE_W-1:0] sz);
        if (sz == 0)
            return 1;
        if (sz > MAX_SIDE)
            return MAX_SIDE;
        return 32'(sz);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $realtime, msg);
    endfunction

    // advance the local image state by one accepted item
    function automatic void rotate_predict(input logic op, input logic [PIX_W-1:0] pix);
        int unsigned n;
        int unsigned total;
        int unsigned src;
        rot_pixel_t  res;
        n     = side_of(size_reg);
        total = n * n;
        if (op == sqrot_pkg::OP_WRITE)
        begin
            if (loaded >= total)
            begin
                loaded = 0;
                rd_row = 0;
                rd_col = 0;
            end
            if (loaded < STORE_DEPTH)
                img_store[loaded] = pix;
            loaded++;
        end
        else if (loaded < total)
        begin
            res = '{pixel: '0, last: 1'b0, nrdy: 1'b1};
            pending_pixels.push_back(res);
        end
        else
        begin
            if (rd_row >= n || rd_col >= n)
            begin
                rd_row = 0;
                rd_col = 0;
            end
            src       = (n - 1 - rd_col) * n + rd_row;
            res.pixel = img_store[src];
            res.last  = (rd_row == n - 1) && (rd_col == n - 1);
            res.nrdy  = 1'b0;
            pending_pixels.push_back(res);
            rd_col++;
            if (rd_col >= n)
            begin
                rd_col = 0;
                rd_row++;
                if (rd_row >= n)
                    rd_row = 0;
            end
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        rot_pixel_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
                note_failure($sformatf("unexpected result pixel=%h last=%b not_ready=%b",
                                       pixel_out, last_pixel, not_ready));
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_out !== want.pixel || last_pixel !== want.last ||
                    not_ready !== want.nrdy)
                    note_failure($sformatf(
                        "mismatch exp pixel=%h last=%b not_ready=%b act pixel=%h last=%b not_ready=%b",
                        want.pixel, want.last, want.nrdy, pixel_out, last_pixel, not_ready));
            end
        end
    end

    // called in the time step of an accepting edge, or later
    task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        pixel_in  <= pix;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        rotate_predict(op, pix);
        items_sent++;
    endtask

    task automatic wait_drained();
        int spins;
        spins = 0;
        start <= 1'b0;
        while (pending_pixels.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        if (pending_pixels.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", pending_pixels.size()));
            pending_pixels.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] sz);
        wait_drained();
        cfg_valid   <= 1'b1;
        matrix_size <= sz;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        size_reg = sz;
        cfg_valid <= 1'b0;
    endtask

    task automatic load_pixels(input int count, input int noise_odds);
        repeat (count)
        begin
            if (noise_odds > 0 && $urandom_range(0, noise_odds - 1) == 0)
                send_item(sqrot_pkg::OP_READ, $urandom());
            send_item(sqrot_pkg::OP_WRITE, $urandom());
        end
    endtask

    task automatic read_pixels(input int count);
        repeat (count) send_item(sqrot_pkg::OP_READ, $urandom());
    endtask

    // extremes, wrap, restart, size 0 and oversize values
    task automatic test_directed();
        no_gaps = 1'b0;
        send_item(sqrot_pkg::OP_READ, 32'hFFFF_FFFF);
        write_size(7'd2);
        send_item(sqrot_pkg::OP_WRITE, 32'h0000_0000);
        send_item(sqrot_pkg::OP_WRITE, 32'hFFFF_FFFF);
        send_item(sqrot_pkg::OP_WRITE, 32'hAAAA_AAAA);
        send_item(sqrot_pkg::OP_WRITE, 32'h5555_5555);
        read_pixels(5);
        // a write after a full image starts over
        send_item(sqrot_pkg::OP_WRITE, 32'h1234_5678);
        send_item(sqrot_pkg::OP_READ, 32'h0);
        send_item(sqrot_pkg::OP_WRITE, 32'h8000_0001);
        send_item(sqrot_pkg::OP_WRITE, 32'h7FFF_FFFE);
        send_item(sqrot_pkg::OP_WRITE, 32'hDEAD_BEEF);
        read_pixels(2);
        // shrink mid readout, size zero acts as one
        write_size(7'd0);
        read_pixels(2);
        write_size(7'h7F);
        send_item(sqrot_pkg::OP_READ, 32'h0);
    endtask

    // back to back load of a large image, then sizes at and above the limit
    task automatic test_large_image();
        no_gaps = 1'b1;
        write_size(SIZE_W'(LARGE_SIDE));
        load_pixels(LARGE_SIDE * LARGE_SIDE, 0);
        no_gaps = 1'b0;
        read_pixels(80);
        write_size(7'd64);
        read_pixels(4);
        write_size(7'h7F);
        read_pixels(10);
        write_size(7'd65);
        read_pixels(10);
    endtask

    task automatic test_random_images();
        int          r;
        int          kind;
        int unsigned n;
        logic [SIZE_W-1:0] sz;
        while (items_sent + ITEM_SLACK < ITEM_TARGET)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                sz = 7'd0;
            else if (r <= 14)
                sz = SIZE_W'($urandom_range(1, 6));
            else
                sz = SIZE_W'($urandom_range(7, 12));
            n       = side_of(sz);
            kind    = $urandom_range(0, 9);
            no_gaps = ($urandom_range(0, 3) == 0);
            write_size(sz);
            case (kind)
                6:
                begin
                    load_pixels($urandom_range(0, n * n - 1), 0);
                    read_pixels($urandom_range(1, 4));
                end
                7:
                begin
                    load_pixels(n * n, 0);
                    read_pixels($urandom_range(0, n * n));
                    load_pixels($urandom_range(1, n * n), 0);
                    read_pixels($urandom_range(1, 4));
                end
                8:
                    read_pixels($urandom_range(1, n * n + 1));
                9:
                begin
                    load_pixels(n * n, 0);
                    wait_drained();
                    read_pixels($urandom_range(1, 2 * n * n + 1));
                end
                default:
                begin
                    load_pixels(n * n, 16);
                    read_pixels($urandom_range(1, 2 * n * n + 1));
                end
            endcase
        end
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        matrix_size <= sqrot_pkg::MATRIX_SIZE_RESET;
        start       <= 1'b0;
        operation   <= sqrot_pkg::OP_WRITE;
        pixel_in    <= '0;
        size_reg    = sqrot_pkg::MATRIX_SIZE_RESET;
        loaded      = 0;
        rd_row      = 0;
        rd_col      = 0;
        fail_count  = 0;
        items_sent  = 0;
        no_gaps     = 1'b0;
        foreach (img_store[i])
            img_store[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_large_image();
        test_random_images();
        wait_drained();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
src/sqrot_pkg.sv
src/sqrot_ram.sv
src/sqrot_front.sv
src/sqrot_queue.sv
src/sqrot_back.sv
src/square_image_rotate_ninety_unit.sv
tb/sv/square_image_rotate_ninety_unit_tb.sv
